[rtl/gbs_pkg.sv]
// ----------------------------------------------------------------------------
// gbs_pkg: shared types and constants of the greedy box suppression unit
// Field layouts of the input and result transfers, the kept-box memory entry
// and the sizing constants of the kept list.
// ----------------------------------------------------------------------------
package gbs_pkg;

  // Capacity of the kept list and length limit of a frame.
  localparam int MAX_KEPT  = 256;
  localparam int MAX_BOXES = 4096;

  localparam int KADDR_W = $clog2(MAX_KEPT);
  localparam int KCNT_W  = $clog2(MAX_KEPT + 1);
  localparam int POS_W   = 12;
  localparam int THR_W   = 16;

  // Highest box position that is reported; later boxes repeat it.
  localparam int POS_LIMIT = (MAX_BOXES - 1 < 4095) ? (MAX_BOXES - 1) : 4095;

  localparam logic [THR_W-1:0] IOU_THR_RESET = 16'd29491;

  typedef struct packed {
    logic               new_frame;
    logic signed [15:0] box_x;
    logic signed [15:0] box_y;
    logic        [14:0] box_w;
    logic        [14:0] box_h;
  } in_t;

  typedef struct packed {
    logic              keep;
    logic [POS_W-1:0]  box_index;
    logic [KCNT_W-1:0] kept_total;
    logic              overflow;
  } out_t;

  // One entry of the kept-box memory.
  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic        [14:0] width;
    logic        [14:0] height;
    logic        [29:0] area;
  } kept_t;

endpackage

[rtl/gbs_ram.sv]
// ----------------------------------------------------------------------------
// gbs_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module gbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/greedy_box_suppression_unit.sv]
// ----------------------------------------------------------------------------
// greedy_box_suppression_unit: class-agnostic greedy non-maximum suppression
// Compares each incoming box with the boxes kept so far in the frame and
// reports whether it survives, storing survivors in an on-chip kept list.
// ----------------------------------------------------------------------------
// Boxes must be presented in descending score order, one box per input
// transfer; a box with new_frame set empties the kept list and restarts the
// box position count before it is processed. Each box is checked against every
// stored box of the current frame by intersection over union, and is
// suppressed when inter * 65536 > iou_threshold * union (exact, no rounding).
// Survivors are stored until the list holds MAX_KEPT boxes; a survivor that
// finds the list full is reported with overflow set and is not stored. For
// each box the stored boxes are read one per cycle through the single read
// port of the kept-box memory, the five-stage compare pipeline then drains,
// the scan ends and the result is posted. If the previous result is still
// stalled at the output register, posting waits for it to leave. The next
// box is accepted at the clock edge after its predecessor's result is posted,
// even while that result is still stalled at the output register, so a new
// box is never taken before the previous box's result has been posted.
// The threshold register may only be written while the block is idle. The
// kept-box memory needs no clearing pass after reset: only entries below the
// current kept count are ever read, and all of those were written in the
// current frame.
// ----------------------------------------------------------------------------
module greedy_box_suppression_unit
  import gbs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // Configuration: the IoU threshold register.
  input  logic             cfg_we_i,
  input  logic [THR_W-1:0] cfg_wdata_i,
  // Box input channel.
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_t              in_data_i,
  // Result output channel.
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_t             out_data_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  // Overlap of two spans along one axis, clamped at zero. The overlap can
  // never exceed either span's length, so it fits the 15-bit size format.
  function automatic logic [14:0] span_overlap(input logic signed [15:0] a0,
                                               input logic        [14:0] aw,
                                               input logic signed [15:0] b0,
                                               input logic        [14:0] bw);
    logic signed [17:0] a_lo;
    logic signed [17:0] b_lo;
    logic signed [17:0] a_hi;
    logic signed [17:0] b_hi;
    logic signed [17:0] lo;
    logic signed [17:0] hi;
    logic signed [17:0] diff;
    a_lo = {{2{a0[15]}}, a0};
    b_lo = {{2{b0[15]}}, b0};
    a_hi = a_lo + signed'({3'b000, aw});
    b_hi = b_lo + signed'({3'b000, bw});
    lo   = (a_lo > b_lo) ? a_lo : b_lo;
    hi   = (a_hi < b_hi) ? a_hi : b_hi;
    diff = hi - lo;
    return (hi > lo) ? diff[14:0] : 15'd0;
  endfunction

  // Control state.
  state_e            state_q;
  logic [KCNT_W-1:0] kept_count_q;
  logic [POS_W-1:0]  frame_pos_q;
  logic [KCNT_W-1:0] rd_idx_q;
  logic              supp_q;
  logic              out_valid_q;
  logic [THR_W-1:0]  thr_q;

  // Payload of the box being processed and of the result register.
  in_t               box_q;
  logic [POS_W-1:0]  box_idx_q;
  logic [29:0]       area_q;
  out_t              out_q;

  // Compare pipeline: valid bits and data of each stage.
  logic              rd_vld_q;
  logic              v1_q;
  logic              v2_q;
  logic              v3_q;
  logic              v4_q;
  logic [14:0]       iw_q;
  logic [14:0]       ih_q;
  logic [29:0]       karea1_q;
  logic [29:0]       inter2_q;
  logic [29:0]       karea2_q;
  logic [30:0]       union3_q;
  logic [29:0]       inter3_q;
  logic [46:0]       prod4_q;
  logic [29:0]       inter4_q;
  logic              nz4_q;

  // Memory interface.
  kept_t             rd_entry;
  kept_t             wr_entry;
  logic              mem_re;
  logic              mem_we;

  // Combinational control.
  logic              in_xfer;
  logic              scan_more;
  logic              scan_done;
  logic              out_free;
  logic              finish_go;
  logic              keep_box;
  logic              list_full;
  logic [KCNT_W-1:0] start_count;
  logic [POS_W-1:0]  start_pos;
  logic [POS_W-1:0]  next_pos;

  assign in_xfer    = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);

  // A new frame restarts the kept list and the box position before this box.
  assign start_count = in_data_i.new_frame ? '0 : kept_count_q;
  assign start_pos   = in_data_i.new_frame ? '0 : frame_pos_q;
  assign next_pos    = (start_pos < POS_W'(POS_LIMIT)) ? (start_pos + 1'b1) : start_pos;

  // One stored box is read per cycle until all of them have been issued; the
  // scan ends once the last read has left the compare pipeline.
  assign scan_more = (state_q == ST_SCAN) && (rd_idx_q < kept_count_q);
  assign scan_done = (state_q == ST_SCAN) && !scan_more && !rd_vld_q &&
                     !v1_q && !v2_q && !v3_q && !v4_q;
  assign mem_re    = scan_more;

  // The result is posted, and a survivor stored, only when the output
  // register is free or is being emptied in this cycle.
  assign out_free  = !out_valid_q || !out_stall_i;
  assign finish_go = (state_q == ST_FINISH) && out_free;
  assign keep_box  = !supp_q;
  assign list_full = (kept_count_q == KCNT_W'(MAX_KEPT));
  assign mem_we    = finish_go && keep_box && !list_full;

  assign wr_entry = '{
    left:   box_q.box_x,
    top:    box_q.box_y,
    width:  box_q.box_w,
    height: box_q.box_h,
    area:   area_q
  };

  gbs_ram #(
    .WIDTH($bits(kept_t)),
    .DEPTH(MAX_KEPT)
  ) u_kept_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(kept_count_q[KADDR_W-1:0]),
    .wdata_i(wr_entry),
    .re_i   (mem_re),
    .raddr_i(rd_idx_q[KADDR_W-1:0]),
    .rdata_o(rd_entry)
  );

  // Threshold register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= IOU_THR_RESET;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // Sequencer: state, counters, suppression flag and the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      kept_count_q <= '0;
      frame_pos_q  <= '0;
      rd_idx_q     <= '0;
      supp_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      rd_vld_q     <= 1'b0;
      v1_q         <= 1'b0;
      v2_q         <= 1'b0;
      v3_q         <= 1'b0;
      v4_q         <= 1'b0;
    end else begin
      rd_vld_q <= mem_re;
      v1_q     <= rd_vld_q;
      v2_q     <= v1_q;
      v3_q     <= v2_q;
      v4_q     <= v3_q;

      // A posted result fills the output register; a delivered one empties it.
      if (finish_go) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      // A new box starts unsuppressed. Any stored box with too much overlap
      // suppresses it.
      if (in_xfer) begin
        supp_q <= 1'b0;
      end else if (v4_q && nz4_q && ({1'b0, inter4_q, 16'h0000} > prod4_q)) begin
        supp_q <= 1'b1;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            kept_count_q <= start_count;
            frame_pos_q  <= next_pos;
            rd_idx_q     <= '0;
            state_q      <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (scan_more) begin
            rd_idx_q <= rd_idx_q + 1'b1;
          end
          if (scan_done) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (finish_go) begin
            if (mem_we) begin
              kept_count_q <= kept_count_q + 1'b1;
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload registers; no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      box_q     <= in_data_i;
      box_idx_q <= start_pos;
    end
    // Area of the current box; settled long before the union stage uses it.
    area_q <= box_q.box_w * box_q.box_h;

    // Stage 1: overlap extents along each axis.
    iw_q     <= span_overlap(box_q.box_x, box_q.box_w, rd_entry.left, rd_entry.width);
    ih_q     <= span_overlap(box_q.box_y, box_q.box_h, rd_entry.top, rd_entry.height);
    karea1_q <= rd_entry.area;

    // Stage 2: intersection area.
    inter2_q <= iw_q * ih_q;
    karea2_q <= karea1_q;

    // Stage 3: union area. The intersection never exceeds either area, so
    // the union is non-negative and fits 31 bits.
    union3_q <= {1'b0, area_q} + {1'b0, karea2_q} - {1'b0, inter2_q};
    inter3_q <= inter2_q;

    // Stage 4: threshold times union.
    prod4_q  <= thr_q * union3_q;
    inter4_q <= inter3_q;
    nz4_q    <= (union3_q != '0);

    if (finish_go) begin
      out_q.keep       <= keep_box;
      out_q.box_index  <= box_idx_q;
      out_q.kept_total <= mem_we ? (kept_count_q + 1'b1) : kept_count_q;
      out_q.overflow   <= keep_box && list_full;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[rtl/gbs_checker.sv]
// ----------------------------------------------------------------------------
// gbs_checker: port-level checks of the greedy box suppression unit
// Watches the channels of the top level and flags results or handshake
// behavior that the design can never produce when it works.
// ----------------------------------------------------------------------------
module gbs_checker
  import gbs_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input out_t             out_data_o
);

  // A stalled result stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or dropped");

  // Boxes are processed one at a time: after an input transfer the block is busy.
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again right after a transfer");

  // Overflow is only reported for a surviving box.
  a_ovf_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.overflow |-> out_data_o.keep)
    else $error("overflow on a suppressed box");

  // The kept list never grows beyond its capacity, and overflow means it is full.
  a_total_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.kept_total <= KCNT_W'(MAX_KEPT)) &&
                    (!out_data_o.overflow ||
                     out_data_o.kept_total == KCNT_W'(MAX_KEPT)))
    else $error("kept total out of range");

  // A stored survivor leaves at least one box in the list.
  a_keep_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.keep && !out_data_o.overflow |->
      out_data_o.kept_total != '0)
    else $error("kept box not counted");

endmodule

bind greedy_box_suppression_unit gbs_checker u_gbs_checker (.*);

[test/gbs_scoreboard_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbs_scoreboard_pkg: verdict scoreboard for the greedy box suppression unit
// Keeps its own kept-box list and IoU threshold, predicts the verdict of every
// accepted box and checks each delivered result against the oldest prediction.
// ----------------------------------------------------------------------------
package gbs_scoreboard_pkg;
  import gbs_pkg::*;

  localparam int PRINT_LIMIT = 200;

  class verdict_scoreboard;
    logic [THR_W-1:0] threshold;
    int               stored_x    [MAX_KEPT];
    int               stored_y    [MAX_KEPT];
    int               stored_w    [MAX_KEPT];
    int               stored_h    [MAX_KEPT];
    longint           stored_area [MAX_KEPT];
    int               stored_count;
    int               box_position;
    out_t             expected_verdicts [$];
    int               mismatches;

    function new();
      threshold    = IOU_THR_RESET;
      stored_count = 0;
      box_position = 0;
      mismatches   = 0;
    endfunction

    function void set_threshold(logic [THR_W-1:0] value);
      threshold = value;
    endfunction

    function int pending();
      return expected_verdicts.size();
    endfunction

    // Length shared by two spans; spans that only touch share nothing.
    function longint shared_span(int a0, int alen, int b0, int blen);
      int lo;
      int hi;
      lo = (a0 > b0) ? a0 : b0;
      hi = (a0 + alen < b0 + blen) ? a0 + alen : b0 + blen;
      return (hi > lo) ? longint'(hi - lo) : 64'sd0;
    endfunction

    function void note_box(in_t box);
      int     x;
      int     y;
      int     w;
      int     h;
      int     k;
      longint area;
      longint inter;
      longint uni;
      bit     keep;
      out_t   verdict;
      x    = {{16{box.box_x[15]}}, box.box_x};
      y    = {{16{box.box_y[15]}}, box.box_y};
      w    = {17'd0, box.box_w};
      h    = {17'd0, box.box_h};
      area = longint'(w) * longint'(h);
      if (box.new_frame) begin
        stored_count = 0;
        box_position = 0;
      end
      verdict           = '0;
      verdict.box_index = box_position[POS_W-1:0];
      if (box_position < POS_LIMIT) box_position++;
      // The box dies if any stored box overlaps it by more than the threshold.
      // A zero union never suppresses.
      keep = 1'b1;
      for (k = 0; k < stored_count; k++) begin
        inter = shared_span(x, w, stored_x[k], stored_w[k]) *
                shared_span(y, h, stored_y[k], stored_h[k]);
        uni   = area + stored_area[k] - inter;
        if (uni != 0 && (inter << 16) > longint'(threshold) * uni) keep = 1'b0;
      end
      if (keep) begin
        if (stored_count < MAX_KEPT) begin
          stored_x[stored_count]    = x;
          stored_y[stored_count]    = y;
          stored_w[stored_count]    = w;
          stored_h[stored_count]    = h;
          stored_area[stored_count] = area;
          stored_count++;
        end else begin
          verdict.overflow = 1'b1;
        end
      end
      verdict.keep       = keep;
      verdict.kept_total = stored_count[KCNT_W-1:0];
      expected_verdicts.insert(expected_verdicts.size(), verdict);
    endfunction

    task report_mismatch(string what, longint got, longint want);
      mismatches++;
      if (mismatches <= PRINT_LIMIT) begin
        $display("[%0t] mismatch in %s: got %0d, expected %0d", $time, what, got, want);
      end
    endtask

    task check_verdict(out_t got);
      out_t want;
      if (expected_verdicts.size() == 0) begin
        report_mismatch("result with no box pending", 64'sd1, 64'sd0);
        return;
      end
      want = expected_verdicts.pop_front();
      if (got.keep !== want.keep) begin
        report_mismatch("keep", longint'(got.keep), longint'(want.keep));
      end
      if (got.box_index !== want.box_index) begin
        report_mismatch("box_index", longint'(got.box_index), longint'(want.box_index));
      end
      if (got.kept_total !== want.kept_total) begin
        report_mismatch("kept_total", longint'(got.kept_total), longint'(want.kept_total));
      end
      if (got.overflow !== want.overflow) begin
        report_mismatch("overflow", longint'(got.overflow), longint'(want.overflow));
      end
    endtask

    task flush_leftovers();
      if (expected_verdicts.size() != 0) begin
        report_mismatch("results never delivered", 64'sd0, longint'(expected_verdicts.size()));
        expected_verdicts.delete();
      end
    endtask
  endclass

endpackage

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for greedy_box_suppression_unit
// Drives boxes through the valid/stall input channel, collects verdicts from
// the output channel and checks every one against a scoreboard that keeps its
// own kept-box list, across several IoU thresholds and idling patterns.
// ----------------------------------------------------------------------------
module testbench;
  import gbs_pkg::*;
  import gbs_scoreboard_pkg::*;

  // The slowest legal run is about nine hundred boxes, each read against up to
  // MAX_KEPT stored boxes, plus stalls and gaps; the limit leaves a wide margin.
  localparam int CYCLE_LIMIT   = 8_000_000;
  // One box is processed per result, so once the last result is out the block
  // is idle; the extra margin covers the result register.
  localparam int SETTLE_CYCLES = 8;
  // At the end wait as long as a full pass over the kept list takes, to catch stray results.
  localparam int TAIL_CYCLES   = MAX_KEPT + 8;
  localparam int DRAIN_LIMIT   = 100_000;
  localparam int LONG_HOLD     = 400;
  localparam int SEGMENT_ITEMS = 100;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [THR_W-1:0] cfg_wdata_i;
  logic             in_valid_i;
  logic             in_stall_o;
  in_t              in_data_i;
  logic             out_valid_o;
  logic             out_stall_i;
  out_t             out_data_o;

  // Idling controls shared between the driving tasks and the stall process.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int          send_quiet    = 0;
  int          recv_quiet    = 0;
  // The main flow bumps hold_requests; the stall process serves each request
  // with one long hold-off that it counts down itself.
  int          hold_requests = 0;
  int          hold_served   = 0;
  int          hold_left     = 0;
  int          cycle_count   = 0;
  bit [31:0]   thr_pick;

  verdict_scoreboard sb;

  greedy_box_suppression_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Receiver side. Stall changes only at the falling edge. Random stalls are
  // broken by quiet stretches, and a pending hold request forces a long
  // stretch of stall so the block backs up into its input channel.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i = 1'b1;
      end else begin
        if (recv_quiet > 0) begin
          recv_quiet--;
        end else if ($urandom_range(63) == 0) begin
          recv_quiet = $urandom_range(40, 10);
        end
        out_stall_i = (recv_quiet == 0) && ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // A result transfer completes at a rising edge with valid high and stall low.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_verdict(out_data_o);
  end

  function automatic in_t make_box(bit nf, int x, int y, int w, int h);
    in_t b;
    b.new_frame = nf;
    b.box_x     = x[15:0];
    b.box_y     = y[15:0];
    b.box_w     = w[14:0];
    b.box_h     = h[14:0];
    return b;
  endfunction

  function automatic int clamp_size(int v);
    return (v < 0) ? 0 : ((v > 32767) ? 32767 : v);
  endfunction

  // Offers one box and returns at the rising edge where the transfer happens.
  // Valid stays high afterwards, so back-to-back boxes need no extra edge;
  // idle cycles lower it at the falling edge before the next offer.
  task automatic send_box(input in_t box);
    @(negedge clk_i);
    if (send_quiet > 0) begin
      send_quiet--;
    end else if ($urandom_range(63) == 0) begin
      send_quiet = $urandom_range(40, 10);
    end
    while (send_quiet == 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = box;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_box(box);
  endtask

  // Drops valid and waits until every predicted verdict has been delivered.
  task automatic settle_block(int extra);
    int waited;
    waited = 0;
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (extra) @(posedge clk_i);
  endtask

  // The threshold may only change while the block is idle.
  task automatic write_threshold(logic [THR_W-1:0] value);
    settle_block(SETTLE_CYCLES);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    sb.set_threshold(value);
  endtask

  // Hand-picked boxes: coordinate and size extremes, disjoint boxes, boxes
  // with zero area and a zero union, identical boxes, IoU exactly at the
  // threshold and above it, and the threshold extremes.
  task automatic run_directed();
    // Reset threshold.
    send_box(make_box(1, -32768, -32768, 32767, 32767));
    send_box(make_box(0, 32767, 32767, 32767, 32767));
    send_box(make_box(0, -32768, -32768, 32767, 32767));
    send_box(make_box(0, 0, 0, 0, 0));
    send_box(make_box(0, 0, 0, 0, 0));
    send_box(make_box(0, -1, -1, 2, 2));
    send_box(make_box(1, 100, 100, 0, 32767));
    send_box(make_box(0, 100, 100, 32767, 0));
    send_box(make_box(0, 16'h5555, 16'hAAAA, 15'h2AAA, 15'h5555));
    // IoU of one half: equal is not enough to suppress, more is.
    write_threshold(16'd32768);
    send_box(make_box(1, 0, 0, 32, 16));
    send_box(make_box(0, 0, 0, 16, 16));
    send_box(make_box(0, 0, 0, 32, 15));
    // A zero threshold suppresses on any overlap, but not on touching edges.
    write_threshold(16'd0);
    send_box(make_box(1, 0, 0, 16, 16));
    send_box(make_box(0, 15, 15, 16, 16));
    send_box(make_box(0, 16, 0, 16, 16));
    // The highest threshold still suppresses an identical box.
    write_threshold(16'hFFFF);
    send_box(make_box(1, 0, 0, 16, 16));
    send_box(make_box(0, 0, 0, 16, 16));
    send_box(make_box(0, 1, 0, 16, 16));
  endtask

  // Short frames of boxes clustered around a few anchors, so that overlaps
  // land on both sides of the threshold, mixed with fully random boxes.
  // pause_at and pressure_at pick the box after which the sender waits for
  // all results, or the receiver holds off for a long stretch.
  task automatic run_random_frames(int count, int pause_at, int pressure_at);
    int        sent;
    int        len;
    int        anchors;
    int        a;
    int        j;
    int        jx;
    int        jy;
    int        ax [3];
    int        ay [3];
    int        aw [3];
    int        ah [3];
    bit        nf;
    bit [31:0] r;
    in_t       box;
    sent = 0;
    while (sent < count) begin
      len     = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
      anchors = $urandom_range(3, 1);
      for (a = 0; a < 3; a++) begin
        ax[a] = ($urandom_range(3) == 0) ? int'($urandom_range(65535)) - 32768
                                         : int'($urandom_range(8000)) - 4000;
        ay[a] = ($urandom_range(3) == 0) ? int'($urandom_range(65535)) - 32768
                                         : int'($urandom_range(8000)) - 4000;
        aw[a] = ($urandom_range(3) == 0) ? $urandom_range(32767) : $urandom_range(1500, 16);
        ah[a] = ($urandom_range(3) == 0) ? $urandom_range(32767) : $urandom_range(1500, 16);
      end
      for (j = 0; j < len && sent < count; j++) begin
        nf = (j == 0) ? ($urandom_range(19) != 0) : ($urandom_range(59) == 0);
        if ($urandom_range(99) < 8) begin
          r         = $urandom;
          box.box_x = r[15:0];
          box.box_y = r[31:16];
          r         = $urandom;
          box.box_w = r[14:0];
          box.box_h = r[30:16];
        end else begin
          a   = $urandom_range(anchors - 1);
          jx  = aw[a] / 8 + 1;
          jy  = ah[a] / 8 + 1;
          box = make_box(nf,
                         ax[a] + int'($urandom_range(2 * jx)) - jx,
                         ay[a] + int'($urandom_range(2 * jy)) - jy,
                         clamp_size(aw[a] + int'($urandom_range(2 * jx)) - jx),
                         clamp_size(ah[a] + int'($urandom_range(2 * jy)) - jy));
        end
        box.new_frame = nf;
        send_box(box);
        sent++;
        if (sent == pause_at) settle_block(SETTLE_CYCLES);
        if (sent == pressure_at) hold_requests++;
      end
    end
  endtask

  // One frame of disjoint boxes on a grid fills the kept list. Later grid
  // boxes overflow, and repeats of the first box are suppressed instead.
  task automatic run_fill_frame();
    int        i;
    bit [31:0] r;
    in_t       box;
    in_t       repeat_box;
    for (i = 0; i < MAX_KEPT + 16; i++) begin
      if (i > MAX_KEPT && i % 3 == 0) begin
        send_box(repeat_box);
      end else begin
        r   = $urandom;
        box = make_box(i == 0, -400 + (i % 17) * 48, 300 + (i / 17) * 48,
                       8 + int'(r[4:0]), 8 + int'(r[12:8]));
        if (i == 0) begin
          repeat_box           = box;
          repeat_box.new_frame = 1'b0;
        end
        send_box(box);
      end
    end
  endtask

  initial begin
    sb          = new();
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Sender mostly busy, receiver mostly stalling.
    send_idle_pct = 18;
    recv_idle_pct = 73;
    run_directed();
    write_threshold(16'd0);
    run_random_frames(SEGMENT_ITEMS, -1, -1);
    write_threshold(16'hFFFF);
    run_random_frames(SEGMENT_ITEMS, -1, -1);

    // Sender mostly idle, receiver mostly ready.
    send_idle_pct = 73;
    recv_idle_pct = 18;
    thr_pick = $urandom;
    write_threshold(thr_pick[15:0]);
    run_random_frames(SEGMENT_ITEMS, -1, -1);
    write_threshold(16'd16384);
    run_random_frames(SEGMENT_ITEMS, -1, -1);

    // No idling on either side; one mid-segment pause of the sender and one
    // long receiver hold-off while the sender keeps offering boxes.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    thr_pick = $urandom;
    write_threshold(thr_pick[15:0]);
    run_random_frames(SEGMENT_ITEMS, 60, -1);
    write_threshold(16'd52000);
    run_random_frames(SEGMENT_ITEMS, -1, 40);

    send_idle_pct = 18;
    recv_idle_pct = 73;
    thr_pick = $urandom;
    write_threshold(thr_pick[15:0]);
    run_fill_frame();

    settle_block(TAIL_CYCLES);
    sb.flush_leftovers();
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
